FILE: rtl/tobm_pkg.sv
`default_nettype none
package tobm_pkg;

  // default widths of the book datapath
  localparam int PRICE_BITS_DEF = 32;
  localparam int SIZE_BITS_DEF  = 32;
  localparam int FRAC_BITS_DEF  = 8;

  // fixed port widths
  localparam int PORT_W    = 32;
  localparam int MID_W     = 33;
  localparam int SPREAD_W  = 33;
  localparam int MICRO_W   = 40;
  localparam int IMB_W     = 16;
  localparam int Q15_SHIFT = 15;

  localparam int QUEUE_DEPTH = 4;

  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_FINISH = 1'b1;
  localparam logic SIDE_BID   = 1'b0;
  localparam logic SIDE_ASK   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MISSING    = 2'd1,
    ST_ZERO_TOTAL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CLS_BID,
    CLS_ASK,
    CLS_FINISH
  } cls_t;

  typedef struct packed {
    cls_t              cls;
    logic [PORT_W-1:0] price;
    logic [PORT_W-1:0] size;
  } entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREP,
    BK_MUL,
    BK_DIV_MICRO,
    BK_DIV_IMB,
    BK_RES
  } bk_state_t;

endpackage
`default_nettype wire

FILE: rtl/tobm_front.sv
`default_nettype none
module tobm_front
  import tobm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              action,
  input  wire logic              side,
  input  wire logic [PORT_W-1:0] price,
  input  wire logic [PORT_W-1:0] size,
  output logic                   q_valid,
  output entry_t                 q_entry,
  input  wire logic              q_stall
);

  logic   hold_valid;
  entry_t hold;
  logic   accept;
  cls_t   cls_in;

  assign in_stall = hold_valid && q_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (action == ACT_FINISH) begin
      cls_in = CLS_FINISH;
    end else if (side == SIDE_ASK) begin
      cls_in = CLS_ASK;
    end else begin
      cls_in = CLS_BID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (!q_stall) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold.cls   <= cls_in;
      hold.price <= price;
      hold.size  <= size;
    end
  end

  assign q_valid = hold_valid;
  assign q_entry = hold;

endmodule
`default_nettype wire

FILE: rtl/tobm_queue.sv
`default_nettype none
module tobm_queue
  import tobm_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   wr_valid,
  output logic        wr_stall,
  input  wire entry_t wr_entry,
  output logic        rd_valid,
  input  wire logic   rd_stall,
  output entry_t      rd_entry
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  entry_t          slots [QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [NW-1:0]   fill;
  logic            push;
  logic            pop;

  assign wr_stall = (fill == NW'(QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= AW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= AW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        fill <= NW'(fill + 1'b1);
      end else if (pop && !push) begin
        fill <= NW'(fill - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tobm_back.sv
`default_nettype none
module tobm_back
  import tobm_pkg::*;
#(
  parameter int PRICE_BITS = PRICE_BITS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  input  wire entry_t                q_entry,
  output logic                       q_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 status,
  output logic [MID_W-1:0]           mid_doubled,
  output logic signed [SPREAD_W-1:0] spread,
  output logic [MICRO_W-1:0]         micro_price,
  output logic signed [IMB_W-1:0]    imbalance
);

  localparam int P   = PRICE_BITS;
  localparam int S   = SIZE_BITS;
  localparam int F   = FRAC_BITS;
  localparam int XPW = (P > PORT_W) ? P : PORT_W;
  localparam int XSW = (S > PORT_W) ? S : PORT_W;
  localparam int PW  = P + S;
  localparam int DVW = (P + S + F > S + Q15_SHIFT) ? (P + S + F) : (S + Q15_SHIFT);
  localparam int CW  = $clog2(DVW);
  localparam int MW  = (P + 1 > MID_W) ? (P + 1) : MID_W;
  localparam int SPW = (P > SPREAD_W) ? P : SPREAD_W;
  localparam int MCW = (P + F + 1 > MICRO_W) ? (P + F + 1) : MICRO_W;
  localparam int QW  = P + F;
  localparam int QIW = Q15_SHIFT + 2;
  localparam logic [QIW-1:0] IMB_MAX = QIW'((1 << (IMB_W - 1)) - 1);

  bk_state_t state, state_next;

  // book
  logic [P-1:0] bid_px, ask_px;
  logic [S-1:0] bid_sz, ask_sz;
  logic         bid_ok, ask_ok;

  // snapshot taken at finish
  logic [P-1:0] s_bid_px, s_ask_px;
  logic [S-1:0] s_bid_sz, s_ask_sz;
  logic         s_bid_ok, s_ask_ok;

  // working registers
  status_t         res_status;
  logic [MID_W-1:0]    res_mid;
  logic [SPREAD_W-1:0] res_spread;
  logic [P-1:0]    lo_px;
  logic [P-1:0]    mcand;
  logic [S-1:0]    mplier;
  logic [S:0]      divisor;
  logic            neg;
  logic [S-1:0]    mag;
  logic [PW-1:0]   prod;
  logic [DVW-1:0]  acc;
  logic [S:0]      rem;
  logic [CW-1:0]   cnt;
  logic [QW-1:0]   q_micro;

  // entry decode
  logic [XPW-1:0] px_x;
  logic [XSW-1:0] sz_x;
  logic [P-1:0]   px;
  logic [S-1:0]   sz;
  logic [S:0]     bid_sum, ask_sum;
  logic [S-1:0]   bid_sat, ask_sat;

  assign px_x    = XPW'(q_entry.price);
  assign sz_x    = XSW'(q_entry.size);
  assign px      = px_x[P-1:0];
  assign sz      = sz_x[S-1:0];
  assign bid_sum = {1'b0, bid_sz} + {1'b0, sz};
  assign ask_sum = {1'b0, ask_sz} + {1'b0, sz};
  assign bid_sat = bid_sum[S] ? '1 : bid_sum[S-1:0];
  assign ask_sat = ask_sum[S] ? '1 : ask_sum[S-1:0];

  // preparation from snapshot
  logic           crossed;
  logic [P-1:0]   lo_sel, hi_sel;
  logic [S-1:0]   w_sel;
  logic           neg_c;
  logic [S-1:0]   mag_c;
  logic [MW-1:0]  mid_sum;
  logic [SPW-1:0] spr_diff;
  status_t        stat_c;

  always_comb begin
    crossed  = s_ask_px < s_bid_px;
    lo_sel   = crossed ? s_ask_px : s_bid_px;
    hi_sel   = crossed ? s_bid_px : s_ask_px;
    w_sel    = crossed ? s_ask_sz : s_bid_sz;
    neg_c    = s_ask_sz > s_bid_sz;
    mag_c    = neg_c ? S'(s_ask_sz - s_bid_sz) : S'(s_bid_sz - s_ask_sz);
    mid_sum  = MW'(s_bid_px) + MW'(s_ask_px);
    spr_diff = SPW'(s_ask_px) - SPW'(s_bid_px);
    if (!(s_bid_ok && s_ask_ok)) begin
      stat_c = ST_MISSING;
    end else if (s_bid_sz == '0 && s_ask_sz == '0) begin
      stat_c = ST_ZERO_TOTAL;
    end else begin
      stat_c = ST_OK;
    end
  end

  // shift-add multiply step, msb of multiplier first
  logic [PW-1:0] prod_next;
  assign prod_next = PW'(prod << 1) + (mplier[S-1] ? PW'(mcand) : '0);

  // restoring divide step
  logic [S+1:0]   rem_sh;
  logic [S+1:0]   rem_sub;
  logic           ge;
  logic [S:0]     rem_next;
  logic [DVW-1:0] acc_next;

  always_comb begin
    rem_sh   = {rem, acc[DVW-1]};
    rem_sub  = rem_sh - {1'b0, divisor};
    ge       = rem_sh >= {1'b0, divisor};
    rem_next = ge ? rem_sub[S:0] : rem_sh[S:0];
    acc_next = {acc[DVW-2:0], ge};
  end

  // final results
  logic [MCW-1:0] micro_sum;
  logic [QIW-1:0] q_imb, q_imb_sat;
  logic [IMB_W-1:0] imb_c;
  logic           out_load;

  always_comb begin
    micro_sum = (MCW'(lo_px) << F) + MCW'(q_micro);
    q_imb     = acc[QIW-1:0];
    q_imb_sat = (!neg && q_imb > IMB_MAX) ? IMB_MAX : q_imb;
    imb_c     = neg ? IMB_W'(-q_imb_sat) : q_imb_sat[IMB_W-1:0];
  end

  assign q_stall  = (state != BK_IDLE);
  assign out_load = (state == BK_RES) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid && q_entry.cls == CLS_FINISH) begin
          state_next = BK_PREP;
        end
      end
      BK_PREP: begin
        state_next = (stat_c == ST_OK) ? BK_MUL : BK_RES;
      end
      BK_MUL: begin
        if (cnt == CW'(S - 1)) begin
          state_next = BK_DIV_MICRO;
        end
      end
      BK_DIV_MICRO: begin
        if (cnt == CW'(DVW - 1)) begin
          state_next = BK_DIV_IMB;
        end
      end
      BK_DIV_IMB: begin
        if (cnt == CW'(DVW - 1)) begin
          state_next = BK_RES;
        end
      end
      BK_RES: begin
        if (out_load) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // book
  always_ff @(posedge clk) begin
    if (rst) begin
      bid_px <= '0;
      bid_sz <= '0;
      ask_px <= '0;
      ask_sz <= '0;
      bid_ok <= 1'b0;
      ask_ok <= 1'b0;
    end else if (state == BK_IDLE && q_valid) begin
      case (q_entry.cls)
        CLS_BID: begin
          if (!bid_ok || px > bid_px) begin
            bid_px <= px;
            bid_sz <= sz;
            bid_ok <= 1'b1;
          end else if (px == bid_px) begin
            bid_sz <= bid_sat;
          end
        end
        CLS_ASK: begin
          if (!ask_ok || px < ask_px) begin
            ask_px <= px;
            ask_sz <= sz;
            ask_ok <= 1'b1;
          end else if (px == ask_px) begin
            ask_sz <= ask_sat;
          end
        end
        CLS_FINISH: begin
          bid_px <= '0;
          bid_sz <= '0;
          ask_px <= '0;
          ask_sz <= '0;
          bid_ok <= 1'b0;
          ask_ok <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (q_valid && q_entry.cls == CLS_FINISH) begin
          s_bid_px <= bid_px;
          s_ask_px <= ask_px;
          s_bid_sz <= bid_sz;
          s_ask_sz <= ask_sz;
          s_bid_ok <= bid_ok;
          s_ask_ok <= ask_ok;
        end
      end
      BK_PREP: begin
        res_status <= stat_c;
        res_mid    <= mid_sum[MID_W-1:0];
        res_spread <= spr_diff[SPREAD_W-1:0];
        lo_px      <= lo_sel;
        mcand      <= P'(hi_sel - lo_sel);
        mplier     <= w_sel;
        divisor    <= {1'b0, s_bid_sz} + {1'b0, s_ask_sz};
        neg        <= neg_c;
        mag        <= mag_c;
        prod       <= '0;
        cnt        <= '0;
      end
      BK_MUL: begin
        prod   <= prod_next;
        mplier <= mplier << 1;
        if (cnt == CW'(S - 1)) begin
          acc <= DVW'(prod_next) << F;
          rem <= '0;
          cnt <= '0;
        end else begin
          cnt <= CW'(cnt + 1'b1);
        end
      end
      BK_DIV_MICRO: begin
        if (cnt == CW'(DVW - 1)) begin
          q_micro <= acc_next[QW-1:0];
          acc     <= DVW'(mag) << Q15_SHIFT;
          rem     <= '0;
          cnt     <= '0;
        end else begin
          acc <= acc_next;
          rem <= rem_next;
          cnt <= CW'(cnt + 1'b1);
        end
      end
      BK_DIV_IMB: begin
        acc <= acc_next;
        rem <= rem_next;
        cnt <= CW'(cnt + 1'b1);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status <= res_status;
      if (res_status == ST_OK) begin
        mid_doubled <= res_mid;
        spread      <= $signed(res_spread);
        micro_price <= micro_sum[MICRO_W-1:0];
        imbalance   <= $signed(imb_c);
      end else begin
        mid_doubled <= '0;
        spread      <= '0;
        micro_price <= '0;
        imbalance   <= '0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/top_of_book_metrics.sv
`default_nettype none
// channel | handshake           | payload
// input   | in_valid / in_stall | action, side, price, size
// output  | out_valid/out_stall | status, mid_doubled, spread, micro_price, imbalance
//
// Level entries flow through an input register and a 4-entry queue; the back end
// takes one entry per cycle while idle, so a run of level entries transfers one per cycle.
// A finish entry occupies the back end through the prepare step, the bit-serial multiplier,
// two passes of the shared restoring divider over DVW = max(PRICE_BITS+SIZE_BITS+FRAC_BITS,
// SIZE_BITS+15) bits (72 at defaults) and the result step; the multiply and divide are
// skipped when a side is missing or the total size is zero.
// Reset clears the book, queue and output flags.
// A held result does not block level entries; the next finish waits for it.
module top_of_book_metrics
  import tobm_pkg::*;
#(
  parameter int PRICE_BITS = PRICE_BITS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  action,
  input  wire logic                  side,
  input  wire logic [PORT_W-1:0]     price,
  input  wire logic [PORT_W-1:0]     size,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 status,
  output logic [MID_W-1:0]           mid_doubled,
  output logic signed [SPREAD_W-1:0] spread,
  output logic [MICRO_W-1:0]         micro_price,
  output logic signed [IMB_W-1:0]    imbalance
);

  logic   f_valid, f_stall;
  entry_t f_entry;
  logic   b_valid, b_stall;
  entry_t b_entry;

  tobm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .side     (side),
    .price    (price),
    .size     (size),
    .q_valid  (f_valid),
    .q_entry  (f_entry),
    .q_stall  (f_stall)
  );

  tobm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_stall (f_stall),
    .wr_entry (f_entry),
    .rd_valid (b_valid),
    .rd_stall (b_stall),
    .rd_entry (b_entry)
  );

  tobm_back #(
    .PRICE_BITS (PRICE_BITS),
    .SIZE_BITS  (SIZE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (b_valid),
    .q_entry     (b_entry),
    .q_stall     (b_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .mid_doubled (mid_doubled),
    .spread      (spread),
    .micro_price (micro_price),
    .imbalance   (imbalance)
  );

endmodule
`default_nettype wire

FILE: sim/top_of_book_metrics_tb.sv
`timescale 1ns / 100ps

module top_of_book_metrics_tb;
  import tobm_pkg::*;

  localparam int ITEMS_TARGET   = 1050;
  localparam int HOLD_CYCLES    = 600;
  localparam int DRAIN_CYCLES   = 250;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    status_t                     status;
    logic [MID_W-1:0]            mid;
    logic signed [SPREAD_W-1:0]  spread;
    logic [MICRO_W-1:0]          micro;
    logic signed [IMB_W-1:0]     imb;
  } metrics_t;

  typedef struct {
    logic              act;
    logic              sd;
    logic [PORT_W-1:0] px;
    logic [PORT_W-1:0] sz;
    bit                typed;
    metrics_t          want;
  } row_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = ACT_ADD;
  logic side = SIDE_BID;
  logic [PORT_W-1:0] price = '0;
  logic [PORT_W-1:0] size = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [MID_W-1:0] mid_doubled;
  logic signed [SPREAD_W-1:0] spread;
  logic [MICRO_W-1:0] micro_price;
  logic signed [IMB_W-1:0] imbalance;

  // predicted book
  logic [PORT_W-1:0] bid_px = '0, bid_sz = '0, ask_px = '0, ask_sz = '0;
  bit bid_ok = 1'b0, ask_ok = 1'b0;

  metrics_t pending_metrics[$];
  row_t dir_rows[$];
  metrics_t no_metrics = '0;
  int mismatches = 0;
  int items_sent = 0;
  bit quiet = 1'b0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;
  logic [PORT_W-1:0] px_base = '0;

  top_of_book_metrics uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .side        (side),
    .price       (price),
    .size        (size),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .mid_doubled (mid_doubled),
    .spread      (spread),
    .micro_price (micro_price),
    .imbalance   (imbalance)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic logic [PORT_W-1:0] sat_size(logic [PORT_W-1:0] a, logic [PORT_W-1:0] b);
    logic [PORT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PORT_W] ? '1 : s[PORT_W-1:0];
  endfunction

  // 0: ignored, 1: book updated, 2: metrics produced and book cleared
  function automatic int book_step(input logic act, input logic sd,
                                   input logic [PORT_W-1:0] px, input logic [PORT_W-1:0] sz,
                                   output metrics_t res);
    logic [PORT_W:0] total;
    logic [PORT_W-1:0] lo_px, hi_px, w;
    logic [127:0] num;
    logic [63:0] mag;
    bit neg;
    res = '0;
    if (act == ACT_ADD) begin
      if (sd == SIDE_BID) begin
        if (!bid_ok || px > bid_px) begin
          bid_px = px;
          bid_sz = sz;
          bid_ok = 1'b1;
          return 1;
        end
        if (px == bid_px) begin
          bid_sz = sat_size(bid_sz, sz);
          return 1;
        end
      end else begin
        if (!ask_ok || px < ask_px) begin
          ask_px = px;
          ask_sz = sz;
          ask_ok = 1'b1;
          return 1;
        end
        if (px == ask_px) begin
          ask_sz = sat_size(ask_sz, sz);
          return 1;
        end
      end
      return 0;
    end
    if (!bid_ok || !ask_ok) begin
      res.status = ST_MISSING;
    end else begin
      total = {1'b0, bid_sz} + {1'b0, ask_sz};
      if (total == '0) begin
        res.status = ST_ZERO_TOTAL;
      end else begin
        res.status = ST_OK;
        res.mid = {1'b0, bid_px} + {1'b0, ask_px};
        res.spread = {1'b0, ask_px} - {1'b0, bid_px};
        if (ask_px >= bid_px) begin
          lo_px = bid_px;
          hi_px = ask_px;
          w = bid_sz;
        end else begin
          lo_px = ask_px;
          hi_px = bid_px;
          w = ask_sz;
        end
        num = 128'(hi_px - lo_px) * 128'(w);
        num = (num << FRAC_BITS_DEF) / 128'(total);
        res.micro = (MICRO_W'(lo_px) << FRAC_BITS_DEF) + MICRO_W'(num);
        neg = ask_sz > bid_sz;
        mag = neg ? 64'(ask_sz - bid_sz) : 64'(bid_sz - ask_sz);
        mag = (mag << Q15_SHIFT) / 64'(total);
        if (!neg && mag > 64'd32767) mag = 64'd32767;
        res.imb = neg ? IMB_W'(64'd0 - mag) : IMB_W'(mag);
      end
    end
    bid_px = '0;
    bid_sz = '0;
    ask_px = '0;
    ask_sz = '0;
    bid_ok = 1'b0;
    ask_ok = 1'b0;
    return 2;
  endfunction

  function automatic int gap_len();
    int r;
    if (quiet || no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [PORT_W-1:0] rand_price();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return px_base + PORT_W'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PORT_W-1:0] rand_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom | 32'hF000_0000;
      3, 4, 5: return PORT_W'($urandom_range(0, 100));
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // called at the edge where a transfer happened
  task automatic send_item(logic act, logic sd, logic [PORT_W-1:0] px, logic [PORT_W-1:0] sz,
                           bit typed, metrics_t typed_want);
    int g;
    int kind;
    metrics_t res;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    side <= sd;
    price <= px;
    size <= sz;
    do @(posedge clk); while (in_stall);
    kind = book_step(act, sd, px, sz, res);
    items_sent++;
    if (kind == 2) pending_metrics.push_back(typed ? typed_want : res);
  endtask

  task automatic send_snapshot(bit well_formed, int min_adds);
    int n;
    bit first_side;
    logic sd;
    n = well_formed ? $urandom_range(min_adds, 8) : $urandom_range(0, 3);
    px_base = ($urandom_range(0, 3) == 0) ? PORT_W'($urandom_range(0, 8)) : $urandom;
    first_side = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      if (well_formed && i < 2) sd = (i == 0) ? first_side : !first_side;
      else sd = 1'($urandom_range(0, 1));
      send_item(ACT_ADD, sd, rand_price(), rand_size(), 1'b0, no_metrics);
    end
    // payload of a finish is don't-care, so randomise it
    send_item(ACT_FINISH, 1'($urandom_range(0, 1)), $urandom, $urandom, 1'b0, no_metrics);
  endtask

  task automatic dir_add(logic sd, logic [PORT_W-1:0] px, logic [PORT_W-1:0] sz);
    row_t r;
    r.act = ACT_ADD;
    r.sd = sd;
    r.px = px;
    r.sz = sz;
    r.typed = 1'b0;
    r.want = '0;
    dir_rows.push_back(r);
  endtask

  task automatic dir_finish(bit typed, status_t st, logic [MID_W-1:0] mid,
                            logic signed [SPREAD_W-1:0] spr, logic [MICRO_W-1:0] mic,
                            logic signed [IMB_W-1:0] imb);
    row_t r;
    r.act = ACT_FINISH;
    r.sd = SIDE_BID;
    r.px = '0;
    r.sz = '0;
    r.typed = typed;
    r.want.status = st;
    r.want.mid = mid;
    r.want.spread = spr;
    r.want.micro = mic;
    r.want.imb = imb;
    dir_rows.push_back(r);
  endtask

  initial begin
    int snap;
    dir_finish(1'b1, ST_MISSING, '0, '0, '0, '0);
    dir_add(SIDE_BID, 100, 10);
    dir_finish(1'b1, ST_MISSING, '0, '0, '0, '0);
    // ask alone with zero size: missing side wins over zero total
    dir_add(SIDE_ASK, 5, 0);
    dir_finish(1'b1, ST_MISSING, '0, '0, '0, '0);
    dir_add(SIDE_BID, '0, '0);
    dir_add(SIDE_ASK, '0, '0);
    dir_finish(1'b1, ST_ZERO_TOTAL, '0, '0, '0, '0);
    dir_add(SIDE_BID, '1, '1);
    dir_add(SIDE_ASK, '1, '1);
    dir_finish(1'b1, ST_OK, 33'h1_FFFF_FFFE, '0, 40'hFF_FFFF_FF00, '0);
    // bid size saturates, worse levels ignored, imbalance clips at +1
    dir_add(SIDE_BID, 1000, 32'hFFFF_FFF0);
    dir_add(SIDE_BID, 1000, 32'h0000_0100);
    dir_add(SIDE_BID, 999, 5);
    dir_add(SIDE_ASK, 1002, 0);
    dir_add(SIDE_ASK, 1003, 7);
    dir_finish(1'b0, ST_OK, '0, '0, '0, '0);
    // crossed book, better ask replaces, imbalance at -1
    dir_add(SIDE_ASK, 50, 3);
    dir_add(SIDE_BID, 60, 0);
    dir_add(SIDE_ASK, 40, 9);
    dir_add(SIDE_BID, 55, 4);
    dir_finish(1'b0, ST_OK, '0, '0, '0, '0);
    dir_add(SIDE_ASK, 7, '1);
    dir_add(SIDE_ASK, 7, '1);
    dir_add(SIDE_BID, 0, 1);
    dir_finish(1'b0, ST_OK, '0, '0, '0, '0);

    do @(posedge clk); while (rst);
    foreach (dir_rows[i])
      send_item(dir_rows[i].act, dir_rows[i].sd, dir_rows[i].px, dir_rows[i].sz,
                dir_rows[i].typed, dir_rows[i].want);

    snap = 0;
    while (items_sent < ITEMS_TARGET) begin
      quiet = ($urandom_range(0, 7) == 0);
      if (snap == 40) begin
        // receiver holds off while we keep pushing: queue fills, input stalls
        hold_req = 1'b1;
        no_gaps = 1'b1;
        repeat (5) send_snapshot(1'b1, 5);
        no_gaps = 1'b0;
      end
      if (snap % 70 == 25) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_metrics.size() != 0);
      end
      send_snapshot($urandom_range(0, 4) != 0, 2);
      snap++;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_metrics.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("** top_of_book_metrics: PASSED **");
    else
      $display("** top_of_book_metrics: FAILED **");
    $finish;
  end

  // result checker and output stall generator
  initial begin
    int hold_left;
    int stall_left;
    int r;
    bit held_once;
    metrics_t e;
    hold_left = 0;
    stall_left = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_metrics.size() == 0) begin
          report_mismatch("unexpected result, status", 64'(status), '0);
        end else begin
          e = pending_metrics.pop_front();
          if (status != e.status) report_mismatch("status", 64'(status), 64'(e.status));
          if (mid_doubled != e.mid) report_mismatch("mid_doubled", 64'(mid_doubled), 64'(e.mid));
          if (spread != e.spread) report_mismatch("spread", 64'(spread), 64'(e.spread));
          if (micro_price != e.micro)
            report_mismatch("micro_price", 64'(micro_price), 64'(e.micro));
          if (imbalance != e.imb) report_mismatch("imbalance", 64'(imbalance), 64'(e.imb));
        end
      end
      if (hold_req && !held_once) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall <= 1'b0;
        end else if (r < 95) begin
          out_stall <= 1'b1;
          stall_left = $urandom_range(0, 3);
        end else begin
          out_stall <= 1'b1;
          stall_left = $urandom_range(15, 60);
        end
      end
    end
  end

  // stops a hung run: cycles without any transfer on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("** top_of_book_metrics: FAILED **");
    $finish;
  end

endmodule
